@@ hw/rtl/graph_depth_first_order_macros.svh @@
// ----------------------------------------------------------------------------
// graph depth-first order assertion macros
// Short forms for concurrent assertions clocked on clk; DFO_ASSERT is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DEPTH_FIRST_ORDER_MACROS_SVH
`define GRAPH_DEPTH_FIRST_ORDER_MACROS_SVH

// checked only while out of reset
`define DFO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define DFO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dfo_pkg.sv @@
// ----------------------------------------------------------------------------
// dfo_pkg
// Shared constants, codes and request/response types of the graph walker.
// ----------------------------------------------------------------------------
package dfo_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VTX_W   = $clog2(MAX_VERTICES);
  localparam int EIDX_W  = $clog2(MAX_EDGES);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
  localparam int SIDX_W  = $clog2(MAX_VERTICES);

  // width of the per-walk visit tag
  localparam int EPOCH_W = 8;

  // fixed field widths of the ports
  localparam int FLD_VTX_W  = 6;
  localparam int NV_W       = 7;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic       OP_ADD = 1'b0;
  localparam logic       OP_RUN = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic              rd_en;
    logic [VTX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [VTX_W-1:0]  wr_addr;
    logic [EIDX_W-1:0] wr_head;
    logic [EIDX_W-1:0] wr_tail;
  } vtx_req_t;

  typedef struct packed {
    logic              valid;
    logic [EIDX_W-1:0] head;
    logic [EIDX_W-1:0] tail;
  } vtx_rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [EIDX_W-1:0] rd_addr;
    logic              tgt_wr_en;
    logic [EIDX_W-1:0] tgt_addr;
    logic [VTX_W-1:0]  tgt_data;
    logic              link_wr_en;
    logic [EIDX_W-1:0] link_addr;
    logic [EIDX_W-1:0] link_data;
  } edge_req_t;

  typedef struct packed {
    logic [VTX_W-1:0]  tgt;
    logic [EIDX_W-1:0] link;
  } edge_rsp_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vtx;
    logic [EIDX_W-1:0] cur;
    logic [EIDX_W-1:0] tail;
    logic              more;
  } stk_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [SIDX_W-1:0] wr_addr;
    stk_entry_t        wr_data;
  } stk_req_t;

endpackage

@@ hw/rtl/dfo_vtx_table.sv @@
// ----------------------------------------------------------------------------
// dfo_vtx_table
// Per-vertex list head and tail in a synchronous memory, with list valid bits.
// ----------------------------------------------------------------------------
module dfo_vtx_table (
  input  logic              clk,
  input  logic              rst_n,
  input  dfo_pkg::vtx_req_t req,
  output dfo_pkg::vtx_rsp_t rsp
);
  import dfo_pkg::*;

  logic [2*EIDX_W-1:0]     mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid_r;
  logic [2*EIDX_W-1:0]     rd_data_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_head, req.wr_tail};
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rsp.valid = rd_valid_r;
  assign rsp.head  = rd_data_r[2*EIDX_W-1:EIDX_W];
  assign rsp.tail  = rd_data_r[EIDX_W-1:0];

endmodule

@@ hw/rtl/dfo_edge_store.sv @@
// ----------------------------------------------------------------------------
// dfo_edge_store
// Edge target and next-edge link memories, one shared read address.
// ----------------------------------------------------------------------------
module dfo_edge_store (
  input  logic               clk,
  input  dfo_pkg::edge_req_t req,
  output dfo_pkg::edge_rsp_t rsp
);
  import dfo_pkg::*;

  logic [VTX_W-1:0]  tgt_mem  [MAX_EDGES];
  logic [EIDX_W-1:0] link_mem [MAX_EDGES];
  logic [VTX_W-1:0]  tgt_rd_r;
  logic [EIDX_W-1:0] link_rd_r;

  always_ff @(posedge clk) begin
    if (req.tgt_wr_en) begin
      tgt_mem[req.tgt_addr] <= req.tgt_data;
    end
    if (req.rd_en) begin
      tgt_rd_r <= tgt_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.link_wr_en) begin
      link_mem[req.link_addr] <= req.link_data;
    end
    if (req.rd_en) begin
      link_rd_r <= link_mem[req.rd_addr];
    end
  end

  assign rsp.tgt  = tgt_rd_r;
  assign rsp.link = link_rd_r;

endmodule

@@ hw/rtl/dfo_stack.sv @@
// ----------------------------------------------------------------------------
// dfo_stack
// Walk stack memory holding the levels below the live top of stack.
// ----------------------------------------------------------------------------
module dfo_stack (
  input  logic                clk,
  input  dfo_pkg::stk_req_t   req,
  output dfo_pkg::stk_entry_t rd_data
);
  import dfo_pkg::*;

  stk_entry_t mem [MAX_VERTICES];
  stk_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/graph_depth_first_order.sv @@
// Edge add: taken in S_IDLE; S_ADD loads the status word once the output register is free.
// Walk: per edge S_STEP, S_EDGE, S_MARK; per new vertex S_PUSH; per pop S_STEP, S_POP;
//   the first walk after reset and every 255th after it first sweep visit marks in S_CLR.
// One item at a time; a finished word waits in the output register while the next is taken.
// Reset (rst_n low, synchronous) empties every edge list, zeroes the edge count and sets
//   the vertex count to 64; the memories themselves are not swept.
// ----------------------------------------------------------------------------
// graph_depth_first_order
// Directed edge store with a pre-order depth-first walk from vertex 0.
// ----------------------------------------------------------------------------
module graph_depth_first_order (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dfo_pkg::NV_W-1:0]       cfg_wr_data,  // num_vertices
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dfo_pkg::IN_DATA_W-1:0]  in_tdata,     // source_vertex, dest_vertex
  input  logic [0:0]                     in_tuser,     // op
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dfo_pkg::OUT_DATA_W-1:0] out_tdata,    // vertex
  output logic [dfo_pkg::STAT_W-1:0]     out_tuser,    // status
  output logic                           out_tlast
);
  import dfo_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD  = 4'd1;
  localparam logic [3:0] S_PUSH = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_EDGE = 4'd4;
  localparam logic [3:0] S_POP  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_MARK = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;

  logic [3:0]              state_r, state_nxt;
  logic [NV_W-1:0]         nv_r, nv_nxt;
  logic [ECNT_W-1:0]       cnt_r, cnt_nxt;
  logic [EPOCH_W-1:0]      epoch_r, epoch_nxt;
  logic [SIDX_W-1:0]       clr_r, clr_nxt;
  logic [DEPTH_W-1:0]      depth_r, depth_nxt;
  logic [VTX_W-1:0]        src_r, src_nxt;
  logic [VTX_W-1:0]        dst_r, dst_nxt;
  logic [STAT_W-1:0]       code_r, code_nxt;
  logic [VTX_W-1:0]        pend_r, pend_nxt;
  logic [VTX_W-1:0]        push_v_r, push_v_nxt;
  stk_entry_t              top_r, top_nxt;

  // visit marks: a vertex is visited when its tag equals the current epoch
  logic [EPOCH_W-1:0]      vis_mem [MAX_VERTICES];
  logic [EPOCH_W-1:0]      vis_rd_r;
  logic                    vis_rd_en;
  logic [VTX_W-1:0]        vis_rd_addr;
  logic                    vis_wr_en;
  logic [VTX_W-1:0]        vis_wr_addr;
  logic [EPOCH_W-1:0]      vis_wr_data;
  logic                    vis_hit;
  logic [EPOCH_W-1:0]      epoch_inc;

  logic                    out_valid_r;
  logic [VTX_W-1:0]        out_vtx_r;
  logic [STAT_W-1:0]       out_stat_r;
  logic                    out_last_r;

  logic                    out_free;
  logic                    emit;
  logic [VTX_W-1:0]        emit_vtx;
  logic [STAT_W-1:0]       emit_stat;
  logic                    emit_last;

  logic [FLD_VTX_W-1:0]    in_src;
  logic [FLD_VTX_W-1:0]    in_dst;
  logic                    in_bad;
  logic [DEPTH_W-1:0]      depth_m1;
  logic [DEPTH_W-1:0]      depth_m2;
  logic [EIDX_W-1:0]       new_idx;

  vtx_req_t   vreq;
  vtx_rsp_t   vrsp;
  edge_req_t  ereq;
  edge_rsp_t  ersp;
  stk_req_t   sreq;
  stk_entry_t srsp;

  dfo_vtx_table u_vtx_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (vreq),
    .rsp   (vrsp)
  );

  dfo_edge_store u_edge_store (
    .clk (clk),
    .req (ereq),
    .rsp (ersp)
  );

  dfo_stack u_stack (
    .clk     (clk),
    .req     (sreq),
    .rd_data (srsp)
  );

  assign in_src   = in_tdata[FLD_VTX_W-1:0];
  assign in_dst   = in_tdata[2*FLD_VTX_W-1:FLD_VTX_W];
  assign in_bad   = (NV_W'(in_src) >= nv_r) || (NV_W'(in_dst) >= nv_r);
  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);
  assign new_idx  = cnt_r[EIDX_W-1:0];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign vis_hit   = (vis_rd_r == epoch_r);
  assign epoch_inc = epoch_r + EPOCH_W'(1);

  // a mark is written in S_MARK and read again no earlier than the next S_EDGE
  always_ff @(posedge clk) begin
    if (vis_wr_en) begin
      vis_mem[vis_wr_addr] <= vis_wr_data;
    end
    if (vis_rd_en) begin
      vis_rd_r <= vis_mem[vis_rd_addr];
    end
  end

  // register write, clamped to the usable range
  always_comb begin
    nv_nxt = nv_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        nv_nxt = NV_W'(1);
      end else if (cfg_wr_data > NV_W'(MAX_VERTICES)) begin
        nv_nxt = NV_W'(MAX_VERTICES);
      end else begin
        nv_nxt = cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    epoch_nxt   = epoch_r;
    clr_nxt     = clr_r;
    depth_nxt   = depth_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    code_nxt    = code_r;
    pend_nxt    = pend_r;
    push_v_nxt  = push_v_r;
    top_nxt     = top_r;
    emit        = 1'b0;
    emit_vtx    = '0;
    emit_stat   = STAT_OK;
    emit_last   = 1'b0;
    vis_rd_en   = 1'b0;
    vis_rd_addr = '0;
    vis_wr_en   = 1'b0;
    vis_wr_addr = '0;
    vis_wr_data = '0;
    vreq        = '0;
    ereq        = '0;
    sreq        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == OP_RUN) begin
            depth_nxt  = '0;
            pend_nxt   = '0;
            push_v_nxt = '0;
            // tags run out: sweep the marks before the walk
            if (epoch_r == '1) begin
              state_nxt = S_CLR;
            end else begin
              epoch_nxt    = epoch_inc;
              vis_wr_en    = 1'b1;
              vis_wr_addr  = '0;
              vis_wr_data  = epoch_inc;
              vreq.rd_en   = 1'b1;
              vreq.rd_addr = '0;
              state_nxt    = S_PUSH;
            end
          end else begin
            src_nxt = in_src[VTX_W-1:0];
            dst_nxt = in_dst[VTX_W-1:0];
            // bad vertex wins over a full store
            priority if (in_bad) begin
              code_nxt = STAT_BAD;
            end else if (cnt_r >= ECNT_W'(MAX_EDGES)) begin
              code_nxt = STAT_FULL;
            end else begin
              code_nxt = STAT_OK;
            end
            vreq.rd_en   = 1'b1;
            vreq.rd_addr = in_src[VTX_W-1:0];
            state_nxt    = S_ADD;
          end
        end
      end

      S_CLR: begin
        // vertex 0 comes out of the sweep marked for the first epoch
        vis_wr_en   = 1'b1;
        vis_wr_addr = clr_r;
        vis_wr_data = (clr_r == '0) ? EPOCH_W'(1) : '0;
        clr_nxt     = clr_r + SIDX_W'(1);
        if (clr_r == SIDX_W'(MAX_VERTICES - 1)) begin
          epoch_nxt    = EPOCH_W'(1);
          vreq.rd_en   = 1'b1;
          vreq.rd_addr = '0;
          state_nxt    = S_PUSH;
        end
      end

      S_ADD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_stat = code_r;
          emit_last = 1'b1;
          if (code_r == STAT_OK) begin
            ereq.tgt_wr_en  = 1'b1;
            ereq.tgt_addr   = new_idx;
            ereq.tgt_data   = dst_r;
            ereq.link_wr_en = vrsp.valid;
            ereq.link_addr  = vrsp.tail;
            ereq.link_data  = new_idx;
            vreq.wr_en      = 1'b1;
            vreq.wr_addr    = src_r;
            vreq.wr_head    = vrsp.valid ? vrsp.head : new_idx;
            vreq.wr_tail    = new_idx;
            cnt_nxt         = cnt_r + ECNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end

      S_PUSH: begin
        // spill the parent level, the new vertex becomes the live top
        if (depth_r != '0) begin
          sreq.wr_en   = 1'b1;
          sreq.wr_addr = depth_m1[SIDX_W-1:0];
          sreq.wr_data = top_r;
        end
        top_nxt.vtx  = push_v_r;
        top_nxt.cur  = vrsp.head;
        top_nxt.tail = vrsp.tail;
        top_nxt.more = vrsp.valid;
        depth_nxt    = depth_r + DEPTH_W'(1);
        state_nxt    = S_STEP;
      end

      S_STEP: begin
        if (!top_r.more) begin
          depth_nxt = depth_m1;
          if (depth_r > DEPTH_W'(1)) begin
            sreq.rd_en   = 1'b1;
            sreq.rd_addr = depth_m2[SIDX_W-1:0];
            state_nxt    = S_POP;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          ereq.rd_en   = 1'b1;
          ereq.rd_addr = top_r.cur;
          state_nxt    = S_EDGE;
        end
      end

      S_EDGE: begin
        vis_rd_en   = 1'b1;
        vis_rd_addr = ersp.tgt;
        state_nxt   = S_MARK;
      end

      S_MARK: begin
        if (!vis_hit) begin
          // previous visit goes out now, the last one is held for the end mark
          if (out_free) begin
            emit     = 1'b1;
            emit_vtx = pend_r;
            if (top_r.cur == top_r.tail) begin
              top_nxt.more = 1'b0;
            end else begin
              top_nxt.cur = ersp.link;
            end
            vis_wr_en    = 1'b1;
            vis_wr_addr  = ersp.tgt;
            vis_wr_data  = epoch_r;
            pend_nxt     = ersp.tgt;
            push_v_nxt   = ersp.tgt;
            vreq.rd_en   = 1'b1;
            vreq.rd_addr = ersp.tgt;
            state_nxt    = S_PUSH;
          end
        end else begin
          if (top_r.cur == top_r.tail) begin
            top_nxt.more = 1'b0;
          end else begin
            top_nxt.cur = ersp.link;
          end
          state_nxt = S_STEP;
        end
      end

      S_POP: begin
        top_nxt   = srsp;
        state_nxt = S_STEP;
      end

      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_vtx  = pend_r;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nv_r        <= NV_W'(MAX_VERTICES);
      cnt_r       <= '0;
      epoch_r     <= '1;
      clr_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      nv_r      <= nv_nxt;
      cnt_r     <= cnt_nxt;
      epoch_r   <= epoch_nxt;
      clr_r     <= clr_nxt;
      depth_r   <= depth_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    code_r   <= code_nxt;
    pend_r   <= pend_nxt;
    push_v_r <= push_v_nxt;
    top_r    <= top_nxt;
    if (emit) begin
      out_vtx_r  <= emit_vtx;
      out_stat_r <= emit_stat;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_vtx_r);
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/dfo_checker.sv @@
// ----------------------------------------------------------------------------
// dfo_checker
// Port-level checks on the graph walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_depth_first_order_macros.svh"

module dfo_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_wr_en,
  input logic [dfo_pkg::NV_W-1:0]       cfg_wr_data,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [dfo_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [0:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [dfo_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [dfo_pkg::STAT_W-1:0]     out_tuser,
  input logic                           out_tlast
);
  import dfo_pkg::*;

  // a stalled word holds
  `DFO_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output word changed while stalled")

  // a rejected edge gives one closing word with vertex zero
  `DFO_ASSERT(a_reject_word, out_tvalid && out_tuser != STAT_OK |-> out_tlast && out_tdata == '0, "rejection word malformed")

  // no item is taken while a walk is still emitting
  `DFO_ASSERT(a_walk_busy, out_tvalid && !out_tlast |-> !in_tready, "input taken in the middle of a walk")

  // reset empties the output side
  `DFO_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind graph_depth_first_order dfo_checker u_dfo_checker (.*);
